FILE: design/sigq_pkg.sv
// Shared types, codes and helpers for the signal record queue.
package sigq_pkg;

   localparam int DEPTH_DEF       = 8;
   localparam int NUM_SIGNALS_DEF = 32;

   localparam int CAP_W    = 4;
   localparam int NUM_W    = 8;
   localparam int VAL_W    = 32;
   localparam int SET_W    = 32;
   localparam int FOUND_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic REQ_QUEUE  = 1'b0;
   localparam logic REQ_ACCEPT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_BUSY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic req_valid;
      logic req_accept;
      logic walk_done;
      logic rsp_free;
   } seq_stat_type;

   typedef struct packed {
      logic req_ready;
      logic start_queue;
      logic start_walk;
      logic walk;
      logic walk_end;
      logic load_rsp;
   } seq_ctrl_type;

   typedef struct packed {
      logic             take;
      logic             keep;
      logic [SET_W-1:0] set_bit;
   } slot_dec_type;

   // One-hot bit for a signal number; numbers beyond the set width give no bit.
   function automatic logic [SET_W-1:0] set_bit(input logic [NUM_W-1:0] num);
      logic [SET_W-1:0] bits;
      bits = '0;
      for (int b = 0; b < SET_W; b++) begin
         bits[b] = (num == NUM_W'(b));
      end
      return bits;
   endfunction

endpackage

FILE: design/sigq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sigq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sigq_slot_unit.sv
// Shared compare unit: classifies one slot read during the search and shift walk.
module sigq_slot_unit
   import sigq_pkg::*;
#(
   parameter int SIG_W = 5
) (
   input  logic             slot_vld,
   input  logic [SIG_W-1:0] slot_sig,
   input  logic [NUM_W-1:0] num,
   input  logic             hit,
   output slot_dec_type     dec
);

   logic [NUM_W-1:0] sig_ext;
   logic             match;

   assign sig_ext = NUM_W'(slot_sig);
   assign match   = (sig_ext == num);

   always_comb begin
      // Only the first matching slot is taken; every other slot stays queued.
      dec.take    = slot_vld && !hit && match;
      dec.keep    = slot_vld && !(!hit && match);
      dec.set_bit = dec.keep ? set_bit(sig_ext) : '0;
   end

endmodule

FILE: design/sigq_seq.sv
// Sequencer for request intake, slot walk and result hand-off.
module sigq_seq
   import sigq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output seq_ctrl_type ctrl
);

   seq_state_type state_ff;
   seq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid) begin
               state_in = stat.req_accept ? ST_WALK : ST_DONE;
            end
         end
         ST_WALK: begin
            if (stat.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready   = 1'b1;
            ctrl.start_queue = stat.req_valid && !stat.req_accept;
            ctrl.start_walk  = stat.req_valid && stat.req_accept;
         end
         ST_WALK: begin
            ctrl.walk     = 1'b1;
            ctrl.walk_end = stat.walk_done;
         end
         ST_DONE: begin
            ctrl.load_rsp = stat.rsp_free;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

FILE: design/signal_info_match_queue.sv
// Top level of the signal record queue with search and remove.
//
//  channel  direction  handshake        payload
//  req      in         valid / ready    type, signal_number, signal_value
//  rsp      out        valid / ready    status, found_signal, found_value, queued_set
//  csr      in         write enable     capacity (4 bits)
//
// A queue request is decided in its accept cycle and its result registered for output.
// An accept request walks the stored records once through the slot RAM read port,
// one slot a cycle, shifting later records down as it goes.
// The block takes the next request while a finished result waits in the output register.
// Reset is synchronous; it empties the queue and sets capacity to the built depth.
module signal_info_match_queue
   import sigq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int NUM_SIGNALS = NUM_SIGNALS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [NUM_W-1:0]    req_signal_number,
   input  logic [VAL_W-1:0]    req_signal_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FOUND_W-1:0]  rsp_found_signal,
   output logic [VAL_W-1:0]    rsp_found_value,
   output logic [SET_W-1:0]    rsp_queued_set,
   input  logic                csr_we,
   input  logic [CAP_W-1:0]    csr_wdata
);

   localparam int SIG_W  = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int SLOT_W = SIG_W + VAL_W;

   seq_stat_type stat;
   seq_ctrl_type ctrl;
   slot_dec_type dec;

   logic [CMP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SET_W-1:0] set_ff, set_in;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [CNT_W-1:0] issue_idx_ff, issue_idx_in;
   logic             data_vld_ff, data_vld_in;
   logic [IDX_W-1:0] data_idx_ff, data_idx_in;
   logic             hit_ff, hit_in;
   logic [SET_W-1:0] acc_set_ff, acc_set_in;

   status_type       status_ff, status_in;
   logic [SIG_W-1:0] got_sig_ff, got_sig_in;
   logic [VAL_W-1:0] got_val_ff, got_val_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [SIG_W-1:0] rsp_sig_ff, rsp_sig_in;
   logic [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic [SET_W-1:0] rsp_set_ff, rsp_set_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [SLOT_W-1:0] wr_data;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_data;
   logic [SIG_W-1:0]  rd_sig;
   logic [VAL_W-1:0]  rd_val;

   logic             num_ok;
   logic             q_busy;
   logic [NUM_W-1:0] got_num_ext;

   assign stat.req_valid  = req_valid;
   assign stat.req_accept = (req_type == REQ_ACCEPT);
   assign stat.walk_done  = (issue_idx_ff == count_ff) && !data_vld_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   sigq_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   assign rd_sig = rd_data[SLOT_W-1:VAL_W];
   assign rd_val = rd_data[VAL_W-1:0];

   sigq_slot_unit #(
      .SIG_W (SIG_W)
   ) u_slot (
      .slot_vld (data_vld_ff),
      .slot_sig (rd_sig),
      .num      (num_ff),
      .hit      (hit_ff),
      .dec      (dec)
   );

   sigq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign num_ok = (req_signal_number < NUM_W'(NUM_SIGNALS));
   assign q_busy = (CMP_W'(count_ff) >= capacity_ff) || (count_ff >= CNT_W'(DEPTH));

   assign rd_en = ctrl.walk && (issue_idx_ff < count_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = {SIG_W'(req_signal_number), req_signal_value};
      if (ctrl.start_queue) begin
         wr_en = num_ok && !q_busy;
      end else if (ctrl.walk && dec.keep && hit_ff) begin
         // Records behind the taken one move one slot toward the head.
         wr_en   = 1'b1;
         wr_addr = data_idx_ff - IDX_W'(1);
         wr_data = rd_data;
      end
   end

   always_comb begin
      capacity_in  = csr_we ? CMP_W'(csr_wdata) : capacity_ff;
      count_in     = count_ff;
      set_in       = set_ff;
      num_in       = num_ff;
      issue_idx_in = issue_idx_ff;
      data_vld_in  = 1'b0;
      data_idx_in  = data_idx_ff;
      hit_in       = hit_ff;
      acc_set_in   = acc_set_ff;
      status_in    = status_ff;
      got_sig_in   = got_sig_ff;
      got_val_in   = got_val_ff;

      if (ctrl.start_queue) begin
         got_sig_in = '0;
         got_val_in = '0;
         if (!num_ok) begin
            status_in = STATUS_INVALID;
         end else if (q_busy) begin
            status_in = STATUS_BUSY;
         end else begin
            status_in = STATUS_OK;
            count_in  = count_ff + CNT_W'(1);
            set_in    = set_ff | set_bit(req_signal_number);
         end
      end

      if (ctrl.start_walk) begin
         num_in       = req_signal_number;
         issue_idx_in = '0;
         hit_in       = 1'b0;
         acc_set_in   = '0;
         got_sig_in   = '0;
         got_val_in   = '0;
      end

      if (ctrl.walk) begin
         if (rd_en) begin
            issue_idx_in = issue_idx_ff + CNT_W'(1);
            data_vld_in  = 1'b1;
            data_idx_in  = issue_idx_ff[IDX_W-1:0];
         end
         acc_set_in = acc_set_ff | dec.set_bit;
         if (dec.take) begin
            hit_in     = 1'b1;
            got_sig_in = rd_sig;
            got_val_in = rd_val;
         end
      end

      if (ctrl.walk_end) begin
         set_in = acc_set_ff;
         if (hit_ff) begin
            status_in = STATUS_OK;
            count_in  = count_ff - CNT_W'(1);
         end else begin
            status_in = STATUS_BUSY;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_sig_in    = rsp_sig_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_set_in    = rsp_set_ff;
      if (ctrl.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_sig_in    = got_sig_ff;
         rsp_val_in    = got_val_ff;
         rsp_set_in    = set_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CMP_W'(DEPTH);
         count_ff     <= '0;
         set_ff       <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         set_ff       <= set_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      issue_idx_ff  <= issue_idx_in;
      data_idx_ff   <= data_idx_in;
      hit_ff        <= hit_in;
      acc_set_ff    <= acc_set_in;
      status_ff     <= status_in;
      got_sig_ff    <= got_sig_in;
      got_val_ff    <= got_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sig_ff    <= rsp_sig_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_set_ff    <= rsp_set_in;
   end

   assign got_num_ext = NUM_W'(rsp_sig_ff);

   assign req_ready        = ctrl.req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_signal = got_num_ext[FOUND_W-1:0];
   assign rsp_found_value  = rsp_val_ff;
   assign rsp_queued_set   = rsp_set_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("record count exceeds the built depth");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      (ctrl.walk && data_vld_ff) |-> (CNT_W'(data_idx_ff) < count_ff))
      else $error("slot read beyond the stored records");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.walk_end && hit_ff) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("removed record not reflected in the count");

   a_shift_after_hit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.walk && wr_en) |-> hit_ff)
      else $error("slot shifted before the matching record was found");

   a_set_size: assert property (@(posedge clock) disable iff (reset)
      ($countones(set_ff) <= int'(count_ff)))
      else $error("queued set has more signals than stored records");

endmodule
